// ===== sv/bpg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpg_pkg
// shared types and constants of the button gesture classifier
// ----------------------------------------------------------------------------
package bpg_pkg;

    // width of the tick counter and its saturation value
    localparam int CountWidth = 13;
    localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

    // threshold registers
    localparam int CfgWidth = 12;
    localparam logic [CfgWidth-1:0] LongPressReset = CfgWidth'(2000);
    localparam logic [CfgWidth-1:0] DoubleGapReset = CfgWidth'(500);

    // common width for counter versus threshold compares
    localparam int CmpWidth = (CountWidth > CfgWidth) ? CountWidth : CfgWidth;

    // apb register map
    localparam int AddrWidth = 3;
    localparam int DataWidth = 32;
    localparam logic RegLongPress = 1'b0;
    localparam logic RegDoubleGap = 1'b1;

    // item opcodes
    typedef enum logic {
        OpTick = 1'b0,
        OpRead = 1'b1
    } t_op;

    // reported gestures
    typedef enum logic [1:0] {
        GNone   = 2'd0,
        GLong   = 2'd1,
        GSingle = 2'd2,
        GDouble = 2'd3
    } t_gesture;

endpackage

// ===== sv/bpg_channel_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpg_item_if / bpg_result_if
// valid/ready channels carrying input items and result items
// ----------------------------------------------------------------------------
interface bpg_item_if;
    import bpg_pkg::*;

    logic valid;
    logic ready;
    t_op  op;
    logic button_level;

    modport source (output valid, output op, output button_level, input ready);
    modport sink (input valid, input op, input button_level, output ready);
endinterface

interface bpg_result_if;
    import bpg_pkg::*;

    logic     valid;
    logic     ready;
    t_gesture gesture;

    modport source (output valid, output gesture, input ready);
    modport sink (input valid, input gesture, output ready);
endinterface

// ===== sv/button_press_gesture_classifier_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_press_gesture_classifier_core
// long press / single click / double click detector for an active-low button
// ----------------------------------------------------------------------------
// Usage:
//   i_item carries one beat per 1 ms tick (op = tick, button_level = raw pin,
//   0 = pressed) or a read beat (op = read) that returns and clears the held
//   gesture. Every input beat produces exactly one beat on o_result; ticks
//   always return "none".
//   The classifier state and the result register are updated at the edge that
//   accepts the beat, and the result is offered on the next cycle. Throughput
//   is one beat per cycle while the receiver keeps up; the single result
//   register is refilled in the same cycle it is drained.
//   When the receiver stalls, the result waits in the output register and
//   i_item.ready drops until it is taken.
//   Reset (i_rst_n low, synchronous) returns the classifier to idle with no
//   gesture held and loads the thresholds with 2000 and 500 ticks.
//   Thresholds are written over the APB port at byte offsets 0 and 4; the user
//   must write them only while the block is idle, which the core does not enforce.
// ----------------------------------------------------------------------------
module button_press_gesture_classifier_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    bpg_item_if.sink                       i_item,
    bpg_result_if.source                   o_result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bpg_pkg::AddrWidth-1:0]  paddr,
    input  logic [bpg_pkg::DataWidth-1:0]  pwdata,
    output logic [bpg_pkg::DataWidth-1:0]  prdata,
    output logic                           pready
);
    import bpg_pkg::*;

    typedef enum logic [1:0] {
        PhIdle      = 2'd0,
        PhPressing  = 2'd1,
        PhReleasing = 2'd2
    } t_phase;

    t_phase                r_phase, n_phase;
    logic [CountWidth-1:0] r_count, n_count;
    t_gesture              r_pend, n_pend;
    t_gesture              n_result;
    logic                  r_out_valid;
    t_gesture              r_out_gesture;
    logic [CfgWidth-1:0]   r_long_thr;
    logic [CfgWidth-1:0]   r_gap_thr;

    logic                  in_acc;
    logic                  cfg_wr;
    logic                  pressed;
    logic [CountWidth-1:0] count_inc;
    logic [CmpWidth-1:0]   cmp_inc;
    logic [CmpWidth-1:0]   cmp_long;
    logic [CmpWidth-1:0]   cmp_gap;
    logic                  one_over_long;
    logic                  one_over_gap;

    // handshakes
    assign i_item.ready = !r_out_valid || o_result.ready;
    assign in_acc       = i_item.valid && i_item.ready;
    assign cfg_wr       = psel && penable && pwrite;
    assign pready       = 1'b1;

    assign o_result.valid   = r_out_valid;
    assign o_result.gesture = r_out_gesture;

    // register readback
    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            RegLongPress: prdata = DataWidth'(r_long_thr);
            RegDoubleGap: prdata = DataWidth'(r_gap_thr);
            default:      prdata = '0;
        endcase
    end

    // saturating increment and threshold compares
    assign pressed       = !i_item.button_level;
    assign count_inc     = (r_count == CountMax) ? CountMax : r_count + 1'b1;
    assign cmp_inc       = CmpWidth'(count_inc);
    assign cmp_long      = CmpWidth'(r_long_thr);
    assign cmp_gap       = CmpWidth'(r_gap_thr);
    assign one_over_long = (r_long_thr == '0);
    assign one_over_gap  = (r_gap_thr == '0);

    // next classifier state and result for the accepted beat
    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_pend   = r_pend;
        n_result = GNone;
        if (in_acc) begin
            if (i_item.op == OpRead) begin
                n_result = r_pend;
                n_pend   = GNone;
            end else if (r_pend == GNone) begin
                unique case (r_phase)
                    PhPressing: begin
                        if (pressed) begin
                            n_count = count_inc;
                            if (cmp_inc > cmp_long) begin
                                n_pend  = GLong;
                                n_phase = PhIdle;
                                n_count = '0;
                            end
                        end else if (one_over_gap) begin
                            n_pend  = GSingle;
                            n_phase = PhIdle;
                            n_count = '0;
                        end else begin
                            n_count = CountWidth'(1);
                            n_phase = PhReleasing;
                        end
                    end
                    PhReleasing: begin
                        if (pressed) begin
                            n_pend  = GDouble;
                            n_phase = PhIdle;
                            n_count = '0;
                        end else begin
                            n_count = count_inc;
                            if (cmp_inc > cmp_gap) begin
                                n_pend  = GSingle;
                                n_phase = PhIdle;
                                n_count = '0;
                            end
                        end
                    end
                    default: begin
                        if (pressed && one_over_long) begin
                            n_pend  = GLong;
                            n_phase = PhIdle;
                            n_count = '0;
                        end else if (pressed) begin
                            n_count = CountWidth'(1);
                            n_phase = PhPressing;
                        end else begin
                            n_phase = PhIdle;
                            n_count = '0;
                        end
                    end
                endcase
            end
        end
    end

    // state, thresholds and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PhIdle;
            r_count     <= '0;
            r_pend      <= GNone;
            r_out_valid <= 1'b0;
            r_long_thr  <= LongPressReset;
            r_gap_thr   <= DoubleGapReset;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_pend  <= n_pend;
            if (in_acc) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_wr) begin
                if (paddr[2] == RegLongPress) begin
                    r_long_thr <= pwdata[CfgWidth-1:0];
                end else begin
                    r_gap_thr <= pwdata[CfgWidth-1:0];
                end
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out_gesture <= n_result;
        end
    end

    // checks
    a_held_is_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend != GNone) |-> (r_phase == PhIdle && r_count == '0))
        else $error("gesture held while a gesture is still being timed");

    a_idle_count_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PhIdle) |-> (r_count == '0))
        else $error("tick count not cleared in idle");

    a_tick_gives_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_item.op == OpTick) |=> (o_result.valid && o_result.gesture == GNone))
        else $error("tick beat returned a gesture");

    a_read_returns_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_item.op == OpRead)
            |=> (o_result.gesture == $past(r_pend) && r_pend == GNone))
        else $error("read did not return and clear the held gesture");

endmodule

// ===== sim/button_press_gesture_classifier_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_press_gesture_classifier_core_tb
// self-checking bench for the long press / single click / double click core
// ----------------------------------------------------------------------------
// Drives tick and read beats into the item channel and compares every result
// beat with a cycle-free model of the classifier kept inside the bench. The
// thresholds are rewritten over APB between phases while the core is drained.
// Directed gestures, zero and maximum thresholds and the reset thresholds are
// covered first, then random gesture sequences with noise under three
// sender/receiver stall patterns.
// ----------------------------------------------------------------------------
module button_press_gesture_classifier_core_tb;
    import bpg_pkg::*;

    localparam int WatchdogLimit = 4000;
    localparam int RandomBeats   = 700;

    typedef enum logic [1:0] {
        PhIdle      = 2'd0,
        PhPressing  = 2'd1,
        PhReleasing = 2'd2
    } t_phase;

    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [AddrWidth-1:0] paddr   = '0;
    logic [DataWidth-1:0] pwdata  = '0;
    logic [DataWidth-1:0] prdata;
    logic                 pready;

    bpg_item_if   item_ch ();
    bpg_result_if result_ch ();

    // gesture model state and thresholds
    logic [CfgWidth-1:0]   long_thr = LongPressReset;
    logic [CfgWidth-1:0]   gap_thr  = DoubleGapReset;
    logic [CountWidth-1:0] tick_cnt = '0;
    t_phase                phase_q  = PhIdle;
    t_gesture              held_q   = GNone;

    t_gesture expected_gestures[$];

    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int beats_sent   = 0;
    int results_seen = 0;
    int mismatches   = 0;
    int idle_cycles  = 0;
    int gesture_hits [4] = '{0, 0, 0, 0};

    button_press_gesture_classifier_core DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------- model

    function automatic logic [CountWidth-1:0] count_bump(logic [CountWidth-1:0] c);
        return (c == CountMax) ? c : c + 1'b1;
    endfunction

    function automatic logic over_thr(logic [CountWidth-1:0] c, logic [CfgWidth-1:0] thr);
        return CmpWidth'(c) > CmpWidth'(thr);
    endfunction

    function automatic void close_gesture(t_gesture g);
        held_q   = g;
        phase_q  = PhIdle;
        tick_cnt = '0;
    endfunction

    // one beat through the model, returns the gesture the core must report
    function automatic t_gesture classify_beat(t_op op, logic level);
        t_gesture g;
        logic     pressed;
        g       = GNone;
        pressed = (level == 1'b0);
        if (op == OpRead) begin
            g      = held_q;
            held_q = GNone;
        end else if (held_q == GNone) begin
            case (phase_q)
                PhPressing: begin
                    if (pressed) begin
                        tick_cnt = count_bump(tick_cnt);
                        if (over_thr(tick_cnt, long_thr)) close_gesture(GLong);
                    end else begin
                        tick_cnt = CountWidth'(1);
                        if (over_thr(tick_cnt, gap_thr)) close_gesture(GSingle);
                        else phase_q = PhReleasing;
                    end
                end
                PhReleasing: begin
                    if (pressed) begin
                        close_gesture(GDouble);
                    end else begin
                        tick_cnt = count_bump(tick_cnt);
                        if (over_thr(tick_cnt, gap_thr)) close_gesture(GSingle);
                    end
                end
                default: begin
                    if (pressed) begin
                        tick_cnt = CountWidth'(1);
                        if (over_thr(tick_cnt, long_thr)) close_gesture(GLong);
                        else phase_q = PhPressing;
                    end else begin
                        phase_q  = PhIdle;
                        tick_cnt = '0;
                    end
                end
            endcase
        end
        return g;
    endfunction

    // ------------------------------------------------------------- receiver

    // random back-pressure on the result channel
    always @(posedge i_clk) begin
        result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // compare each result beat with the oldest expected gesture
    always @(posedge i_clk) begin
        t_gesture want;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            results_seen++;
            gesture_hits[result_ch.gesture]++;
            if (expected_gestures.size() == 0) begin
                if (mismatches < 10)
                    $display("[%0t] unexpected result beat, gesture %0d",
                             $realtime, result_ch.gesture);
                mismatches++;
            end else begin
                want = expected_gestures.pop_front();
                if (result_ch.gesture !== want) begin
                    if (mismatches < 10)
                        $display("[%0t] gesture mismatch: expected %0d, got %0d",
                                 $realtime, want, result_ch.gesture);
                    mismatches++;
                end
            end
        end
    end

    // stop the run when no beat moves for too long
    always @(posedge i_clk) begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
                || psel || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WatchdogLimit) begin
                $display("watchdog expired with %0d results outstanding",
                         expected_gestures.size());
                $display("simulation failed");
                $finish;
            end
        end
    end

    // --------------------------------------------------------------- sender

    task automatic send_beat(input t_op op, input logic level);
        while ($urandom_range(99) < tx_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.op           <= op;
        item_ch.button_level <= level;
        do @(posedge i_clk); while (!item_ch.ready);
        expected_gestures.push_back(classify_beat(op, level));
        beats_sent++;
    endtask

    task automatic hold_pressed(input int n);
        repeat (n) send_beat(OpTick, 1'b0);
    endtask

    task automatic hold_released(input int n);
        repeat (n) send_beat(OpTick, 1'b1);
    endtask

    // read beats carry a random pin level, which the core must ignore
    task automatic read_gesture();
        send_beat(OpRead, 1'(($urandom_range(1))));
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain();
        item_ch.valid <= 1'b0;
        while (expected_gestures.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AddrWidth'({idx, 2'b00});
        pwdata  <= DataWidth'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == RegLongPress) long_thr = CfgWidth'(value);
        else gap_thr = CfgWidth'(value);
        // bus returns to idle before the next transfer
        @(posedge i_clk);
    endtask

    task automatic set_thresholds(input int unsigned lp, input int unsigned gap);
        write_reg(RegLongPress, lp);
        write_reg(RegDoubleGap, gap);
    endtask

    // ---------------------------------------------------------------- tests

    // short click under the thresholds loaded by reset
    task automatic test_reset_thresholds();
        tx_idle_pct = 10;
        rx_idle_pct = 10;
        hold_pressed(5);
        hold_released(int'(DoubleGapReset) + 1);
        read_gesture();
        drain();
    endtask

    // each gesture once, reads with and without a held gesture
    task automatic test_directed_gestures();
        set_thresholds(3, 2);
        // long press, ticks ignored while held, then empty read
        hold_pressed(4);
        hold_pressed(1);
        hold_released(1);
        read_gesture();
        read_gesture();
        // single click from an idle start
        hold_released(1);
        hold_pressed(1);
        hold_released(3);
        read_gesture();
        // double click
        hold_pressed(1);
        hold_released(1);
        hold_pressed(1);
        read_gesture();
        // read while a gesture is still in progress leaves it running
        hold_pressed(1);
        hold_released(1);
        read_gesture();
        hold_released(2);
        read_gesture();
        drain();
    endtask

    // zero thresholds report on the first pressed or released sample
    task automatic test_zero_thresholds();
        set_thresholds(0, 4095);
        hold_pressed(1);
        read_gesture();
        drain();
        set_thresholds(4095, 0);
        hold_pressed(1);
        hold_released(1);
        read_gesture();
        drain();
    endtask

    // largest thresholds stay quiet over a long hold, then a double click
    task automatic test_max_thresholds();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_thresholds(4095, 4095);
        hold_pressed(200);
        hold_released(1);
        hold_pressed(1);
        read_gesture();
        drain();
    endtask

    // random gestures with noise; thresholds change between drained bursts
    task automatic test_random_traffic(input int n_beats, input int tx_pct, input int rx_pct);
        int stop_at;
        int pause_at;
        int lp;
        int gap;
        bit paused;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        stop_at     = beats_sent + n_beats;
        pause_at    = beats_sent + n_beats / 2;
        paused      = 1'b0;
        while (beats_sent < stop_at) begin
            if ($urandom_range(3) == 0) begin
                lp  = $urandom_range(60);
                gap = $urandom_range(60);
            end else begin
                lp  = $urandom_range(12);
                gap = $urandom_range(12);
            end
            set_thresholds(lp, gap);
            repeat ($urandom_range(8, 3)) begin
                if ($urandom_range(99) < 15) begin
                    // noise: any op, any level
                    repeat ($urandom_range(4, 1))
                        send_beat(t_op'($urandom_range(1)), 1'($urandom_range(1)));
                end else begin
                    hold_pressed($urandom_range(lp + 3, 1));
                    hold_released($urandom_range(gap + 3, 1));
                    if ($urandom_range(1)) begin
                        hold_pressed($urandom_range(3, 1));
                        hold_released($urandom_range(3, 1));
                    end
                    read_gesture();
                    if ($urandom_range(3) == 0) read_gesture();
                end
                // sender waits once for the core to run dry mid-phase
                if (!paused && beats_sent >= pause_at) begin
                    drain();
                    paused = 1'b1;
                end
            end
            drain();
        end
    endtask

    // ------------------------------------------------------------- sequence

    initial begin
        item_ch.valid        = 1'b0;
        item_ch.op           = OpTick;
        item_ch.button_level = 1'b1;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_thresholds();
        test_directed_gestures();
        test_zero_thresholds();
        test_max_thresholds();
        test_random_traffic(RandomBeats / 3, 34, 81);
        test_random_traffic(RandomBeats / 3, 81, 34);
        test_random_traffic(RandomBeats - 2 * (RandomBeats / 3), 0, 0);
        drain();

        $display("%0d item beats sent, %0d result beats checked, %0d mismatches",
                 beats_sent, results_seen, mismatches);
        $display("reported gestures: %0d long, %0d single, %0d double",
                 gesture_hits[GLong], gesture_hits[GSingle], gesture_hits[GDouble]);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
